@@ rtl/core/ila_pkg.sv @@
// ----------------------------------------------------------------------------
// ila_pkg
// Shared widths, codes and types of the indel left-align unit.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam int SYM_W           = 8;    // column symbol width
  localparam int IDX_W           = 9;    // read-back index width
  localparam int CNT_OUT_W       = 10;   // reported column count width
  localparam int S_TDATA_W       = 32;
  localparam int M_TDATA_W       = 48;
  localparam int MAX_COLUMNS_DEF = 512;

  localparam logic [SYM_W-1:0] GAP_RESET = 8'd45;

  // tuser codes on the input stream
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // kind of the indel run being tracked by the justify scan
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DEL,
    KIND_INS
  } kind_e;

endpackage

@@ rtl/core/indel_left_align_unit.sv @@
// ----------------------------------------------------------------------------
// indel_left_align_unit
// Loads an alignment column by column, left-justifies its indel runs and
// returns any column with its read-base ordinal and reference offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser selects load (0) or read (1). A load transfer
//   stores one column (tdata read/ref symbol); tlast marks the final column
//   and starts justification. A load after justification has finished
//   begins a new alignment.
//   Justification runs a scan over the column RAM, one column at a time.
//   A run closed by a gap-free column slides left: each column before it is
//   checked, and each shift writes both columns and fetches the new run end
//   (a run at column 0 stays); the scan then resumes right after the moved run.
//   Input is held off meanwhile.
//   A read transfer walks columns 0..index through the RAM read port to sum
//   the ordinal and offset into the output register; an index at or beyond
//   the column count answers with zero fields but the column count.
//   Loads give no result on m_axis.
//   The output register holds one result; if m_axis stalls, the unit still
//   takes loads and a read computes, then waits for the register to free.
//   cfg_wr_en_i writes the gap symbol; write it only while idle.
//   Reset empties the alignment and sets the gap symbol to '-' (45). The
//   column RAM is not cleared; only loaded columns are ever read.
// ----------------------------------------------------------------------------
module indel_left_align_unit #(
  parameter int MAX_COLUMNS = ila_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config: gap symbol
  input  logic                          cfg_wr_en_i,
  input  logic [ila_pkg::SYM_W-1:0]     cfg_wr_data_i,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] read_symbol, [15:8] ref_symbol, [24:16] index, [31:25] zero
  input  logic [ila_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] operation
  input  logic [0:0]                    s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  // output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] out_read_symbol, [15:8] out_ref_symbol, [16] has_read_base,
  // [25:17] read_ordinal, [34:26] ref_offset, [44:35] column_count,
  // [47:45] zero
  output logic [ila_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import ila_pkg::*;

  localparam int AW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CW   = $clog2(MAX_COLUMNS + 1);
  localparam int CmpW = (CW > IDX_W) ? CW : IDX_W;
  localparam int WW   = 2 * SYM_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_JS      = 3'd1;  // justify start
  localparam logic [2:0] ST_SC_EV   = 3'd2;  // scan: evaluate column i
  localparam logic [2:0] ST_SL_CK   = 3'd3;  // slide: check column s
  localparam logic [2:0] ST_SL_WS   = 3'd4;  // slide: write column s
  localparam logic [2:0] ST_SL_RE   = 3'd5;  // slide: fetch new run end
  localparam logic [2:0] ST_RD_SCAN = 3'd6;
  localparam logic [2:0] ST_RD_OUT  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 offsets_ready_q, offsets_ready_d;
  logic [SYM_W-1:0]     gap_q, gap_d;
  logic [CW-1:0]        i_q, i_d;
  logic [AW-1:0]        first_q, first_d;
  logic [AW-1:0]        end_q, end_d;
  logic [AW-1:0]        s_q, s_d;
  kind_e                kind_q, kind_d;
  logic [SYM_W-1:0]     end_cs_q, end_cs_d;
  logic [SYM_W-1:0]     cs_s_q, cs_s_d;
  logic [AW-1:0]        k_q, k_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [SYM_W-1:0]     res_rd_q, res_rd_d;
  logic [SYM_W-1:0]     res_rf_q, res_rf_d;
  logic                 res_hb_q, res_hb_d;
  logic [IDX_W-1:0]     ord_q, ord_d;
  logic [IDX_W-1:0]     off_q, off_d;
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WW-1:0]        ram_rdata;

  logic                 in_xfer;
  logic [SYM_W-1:0]     in_rd, in_rf, q_rd, q_rf;
  logic [IDX_W-1:0]     in_idx;
  logic [CW-1:0]        eff_cnt, i_inc, end_inc;
  logic                 is_del, is_ins, is_del_run, slide_ok;
  logic [SYM_W-1:0]     gs_s, cs_s;

  // column word: [15:8] reference symbol, [7:0] read symbol
  ila_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_COLUMNS)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_rd           = s_axis_tdata_i[7:0];
  assign in_rf           = s_axis_tdata_i[15:8];
  assign in_idx          = s_axis_tdata_i[24:16];
  assign q_rd            = ram_rdata[SYM_W-1:0];
  assign q_rf            = ram_rdata[WW-1:SYM_W];
  assign eff_cnt         = offsets_ready_q ? '0 : cnt_q;
  assign i_inc           = i_q + CW'(1);
  assign end_inc         = CW'(end_q) + CW'(1);
  assign is_del          = (q_rd == gap_q);
  assign is_ins          = !is_del && (q_rf == gap_q);
  assign is_del_run      = (kind_q == KIND_DEL);
  // gap-side and compare-side symbol of the column before the run
  assign gs_s            = is_del_run ? q_rd : q_rf;
  assign cs_s            = is_del_run ? q_rf : q_rd;
  assign slide_ok        = !is_del && (q_rf != gap_q) && (cs_s == end_cs_q);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    offsets_ready_d = offsets_ready_q;
    gap_d           = cfg_wr_en_i ? cfg_wr_data_i : gap_q;
    i_d             = i_q;
    first_d         = first_q;
    end_d           = end_q;
    s_d             = s_q;
    kind_d          = kind_q;
    end_cs_d        = end_cs_q;
    cs_s_d          = cs_s_q;
    k_d             = k_q;
    rd_idx_d        = rd_idx_q;
    res_rd_d        = res_rd_q;
    res_rf_d        = res_rf_q;
    res_hb_d        = res_hb_q;
    ord_d           = ord_q;
    off_d           = off_q;
    m_valid_d       = m_valid_q && !m_axis_tready_i;
    m_data_d        = m_data_q;
    ram_we          = 1'b0;
    ram_waddr       = end_q;
    ram_wdata       = {q_rf, q_rd};
    ram_raddr       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser_i[0] == OP_LOAD) begin
            offsets_ready_d = 1'b0;
            cnt_d           = eff_cnt;
            if (eff_cnt < CW'(MAX_COLUMNS)) begin
              ram_we    = 1'b1;
              ram_waddr = eff_cnt[AW-1:0];
              ram_wdata = {in_rf, in_rd};
              cnt_d     = eff_cnt + CW'(1);
            end
            if (s_axis_tlast_i) begin
              state_d = ST_JS;
            end
          end else begin
            k_d      = '0;
            rd_idx_d = AW'(in_idx);
            ord_d    = '0;
            off_d    = '0;
            res_rd_d = '0;
            res_rf_d = '0;
            res_hb_d = 1'b0;
            if (CmpW'(in_idx) < CmpW'(cnt_q)) begin
              state_d = ST_RD_SCAN;
            end else begin
              state_d = ST_RD_OUT;
            end
          end
        end
      end

      ST_JS: begin
        i_d       = '0;
        kind_d    = KIND_NONE;
        ram_raddr = '0;
        state_d   = ST_SC_EV;
      end

      ST_SC_EV: begin
        if (is_del || is_ins || (kind_q == KIND_NONE)) begin
          if (is_del || is_ins) begin
            kind_d   = is_del ? KIND_DEL : KIND_INS;
            if (kind_q != kind_d) begin
              first_d = i_q[AW-1:0];
            end
            end_d    = i_q[AW-1:0];
            end_cs_d = is_del ? q_rf : q_rd;
          end
          if (i_inc == cnt_q) begin
            // a run still open here ends the alignment and stays put
            offsets_ready_d = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            i_d       = i_inc;
            ram_raddr = i_inc[AW-1:0];
          end
        end else if (first_q == '0) begin
          // run starts at column 0: nothing to slide into, re-scan column i
          kind_d    = KIND_NONE;
          ram_raddr = i_q[AW-1:0];
        end else begin
          s_d       = first_q - AW'(1);
          ram_raddr = first_q - AW'(1);
          state_d   = ST_SL_CK;
        end
      end

      ST_SL_CK: begin
        if (slide_ok) begin
          ram_we    = 1'b1;
          ram_waddr = end_q;
          ram_wdata = is_del_run ? {end_cs_q, gs_s} : {gs_s, end_cs_q};
          cs_s_d    = cs_s;
          state_d   = ST_SL_WS;
        end else begin
          kind_d    = KIND_NONE;
          i_d       = end_inc;
          ram_raddr = end_inc[AW-1:0];
          state_d   = ST_SC_EV;
        end
      end

      ST_SL_WS: begin
        ram_we    = 1'b1;
        ram_waddr = s_q;
        ram_wdata = is_del_run ? {cs_s_q, gap_q} : {gap_q, cs_s_q};
        ram_raddr = end_q - AW'(1);
        state_d   = ST_SL_RE;
      end

      ST_SL_RE: begin
        end_cs_d = is_del_run ? q_rf : q_rd;
        end_d    = end_q - AW'(1);
        if (s_q == '0) begin
          kind_d    = KIND_NONE;
          i_d       = CW'(end_q);
          ram_raddr = end_q;
          state_d   = ST_SC_EV;
        end else begin
          s_d       = s_q - AW'(1);
          ram_raddr = s_q - AW'(1);
          state_d   = ST_SL_CK;
        end
      end

      ST_RD_SCAN: begin
        // ram_rdata holds column k_q, read in the previous cycle
        if (k_q == rd_idx_q) begin
          res_rd_d = q_rd;
          res_rf_d = q_rf;
          res_hb_d = !is_del;
          state_d  = ST_RD_OUT;
        end else begin
          ord_d     = ord_q + IDX_W'(!is_del);
          off_d     = off_q + IDX_W'(q_rf != gap_q);
          k_d       = k_q + AW'(1);
          ram_raddr = k_q + AW'(1);
        end
      end

      ST_RD_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, CNT_OUT_W'(cnt_q), off_q, ord_q, res_hb_q, res_rf_q, res_rd_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cnt_q           <= '0;
      offsets_ready_q <= 1'b0;
      gap_q           <= GAP_RESET;
      kind_q          <= KIND_NONE;
      m_valid_q       <= 1'b0;
    end else begin
      state_q         <= state_d;
      cnt_q           <= cnt_d;
      offsets_ready_q <= offsets_ready_d;
      gap_q           <= gap_d;
      kind_q          <= kind_d;
      m_valid_q       <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    first_q  <= first_d;
    end_q    <= end_d;
    s_q      <= s_d;
    end_cs_q <= end_cs_d;
    cs_s_q   <= cs_s_d;
    k_q      <= k_d;
    rd_idx_q <= rd_idx_d;
    res_rd_q <= res_rd_d;
    res_rf_q <= res_rf_d;
    res_hb_q <= res_hb_d;
    ord_q    <= ord_d;
    off_q    <= off_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_COLUMNS))
    else $error("column count above capacity");

  a_not_ready_in_justify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_JS || state_q == ST_SC_EV || state_q == ST_SL_CK ||
     state_q == ST_SL_WS || state_q == ST_SL_RE) |-> !offsets_ready_q)
    else $error("offsets ready during justification");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SC_EV) |-> (i_q < cnt_q))
    else $error("justify scan index beyond loaded columns");

  a_slide_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SL_CK || state_q == ST_SL_WS) |-> (s_q < end_q))
    else $error("slide source not left of run end");

  a_slide_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SL_CK || state_q == ST_SL_WS || state_q == ST_SL_RE)
    |-> (kind_q != KIND_NONE))
    else $error("slide without an open run");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |=> $stable(m_data_q))
    else $error("pending result overwritten");
`endif

endmodule

@@ rtl/core/ila_ram.sv @@
// ----------------------------------------------------------------------------
// ila_ram
// Simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module ila_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/sv/indel_align_checker.sv @@
// ----------------------------------------------------------------------------
// indel_align_checker
// Watches the config port and both streams of the indel left-align unit.
// Keeps its own copy of the column store, left-justifies indel runs when the
// last column lands, and checks every returned column field by field.
// ----------------------------------------------------------------------------
module indel_align_checker #(
  parameter int MAX_COLUMNS = ila_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [ila_pkg::SYM_W-1:0]     cfg_wr_data_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // [7:0] read_symbol, [15:8] ref_symbol, [24:16] index, [31:25] zero
  input  logic [ila_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] operation
  input  logic [0:0]                    s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // [7:0] out_read_symbol, [15:8] out_ref_symbol, [16] has_read_base,
  // [25:17] read_ordinal, [34:26] ref_offset, [44:35] column_count
  input  logic [ila_pkg::M_TDATA_W-1:0] m_axis_tdata_i,
  output int unsigned                   error_count_o,
  output int unsigned                   pending_o
);

  import ila_pkg::*;

  // first member sits in the top bits, so the lowest tdata field comes last
  typedef struct packed {
    logic [CNT_OUT_W-1:0] column_count;
    logic [IDX_W-1:0]     ref_offset;
    logic [IDX_W-1:0]     read_ordinal;
    logic                 has_read_base;
    logic [SYM_W-1:0]     ref_symbol;
    logic [SYM_W-1:0]     read_symbol;
  } column_view_t;

  logic [SYM_W-1:0] read_col [MAX_COLUMNS];
  logic [SYM_W-1:0] ref_col  [MAX_COLUMNS];
  int               loaded_n;
  bit               justified;
  logic [SYM_W-1:0] gap_sym;
  column_view_t     expected_columns [$];

  // Moves one run left while the column ahead of it is gap free and carries
  // the same base as the run's tail. Returns the new tail.
  function automatic int slide_gap_run(bit del_run, int first, int tail);
    int               s;
    logic [SYM_W-1:0] base_s;
    logic [SYM_W-1:0] base_t;
    s = first - 1;
    while (s >= 0) begin
      if (read_col[s] == gap_sym || ref_col[s] == gap_sym) break;
      base_s = del_run ? ref_col[s]    : read_col[s];
      base_t = del_run ? ref_col[tail] : read_col[tail];
      if (base_s != base_t) break;
      if (del_run) begin
        read_col[tail] = read_col[s];
        read_col[s]    = gap_sym;
      end else begin
        ref_col[tail] = ref_col[s];
        ref_col[s]    = gap_sym;
      end
      s--;
      tail--;
    end
    return tail;
  endfunction

  // A run only moves once a gap-free column closes it, so trailing runs stay.
  function automatic void left_justify_runs();
    int    i;
    int    first;
    int    tail;
    kind_e kind;
    i     = 0;
    first = -1;
    tail  = -1;
    kind  = KIND_NONE;
    while (i < loaded_n) begin
      if (read_col[i] == gap_sym) begin
        if (kind != KIND_DEL) first = i;
        kind = KIND_DEL;
        tail = i;
        i++;
      end else if (ref_col[i] == gap_sym) begin
        if (kind != KIND_INS) first = i;
        kind = KIND_INS;
        tail = i;
        i++;
      end else begin
        if (kind == KIND_DEL) i = slide_gap_run(1'b1, first, tail) + 1;
        else if (kind == KIND_INS) i = slide_gap_run(1'b0, first, tail) + 1;
        else i++;
        kind  = KIND_NONE;
        first = -1;
        tail  = -1;
      end
    end
  endfunction

  function automatic column_view_t predict_column(int idx);
    column_view_t v;
    v              = '0;
    v.column_count = CNT_OUT_W'(loaded_n);
    if (idx < loaded_n) begin
      for (int k = 0; k < idx; k++) begin
        if (read_col[k] != gap_sym) v.read_ordinal++;
        if (ref_col[k] != gap_sym) v.ref_offset++;
      end
      v.read_symbol   = read_col[idx];
      v.ref_symbol    = ref_col[idx];
      v.has_read_base = (read_col[idx] != gap_sym);
    end
    return v;
  endfunction

  task automatic store_column(logic [SYM_W-1:0] rs, logic [SYM_W-1:0] fs, logic last);
    if (justified) begin
      loaded_n  = 0;
      justified = 1'b0;
    end
    // a full store drops the column, but a last flag still justifies
    if (loaded_n < MAX_COLUMNS) begin
      read_col[loaded_n] = rs;
      ref_col[loaded_n]  = fs;
      loaded_n++;
    end
    if (last) begin
      left_justify_runs();
      justified = 1'b1;
    end
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    column_view_t got;
    column_view_t want;
    if (!rst_ni) begin
      loaded_n      = 0;
      justified     = 1'b0;
      gap_sym       = GAP_RESET;
      error_count_o = 0;
      expected_columns.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = column_view_t'(m_axis_tdata_i[$bits(column_view_t)-1:0]);
        if (expected_columns.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none actual %h",
                   $time, m_axis_tdata_i);
          error_count_o++;
        end else begin
          want = expected_columns.pop_front();
          check_field("out_read_symbol", want.read_symbol, got.read_symbol);
          check_field("out_ref_symbol", want.ref_symbol, got.ref_symbol);
          check_field("has_read_base", want.has_read_base, got.has_read_base);
          check_field("read_ordinal", want.read_ordinal, got.read_ordinal);
          check_field("ref_offset", want.ref_offset, got.ref_offset);
          check_field("column_count", want.column_count, got.column_count);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i[0] == OP_READ)
          expected_columns.push_back(predict_column(int'(s_axis_tdata_i[24:16])));
        else
          store_column(s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tlast_i);
      end
      if (cfg_wr_en_i) gap_sym = cfg_wr_data_i;
    end
    pending_o = expected_columns.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the indel left-align unit: directed columns around
// homopolymer indels, then random alignments under several gap symbols and
// idle patterns, with one long output stall. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import ila_pkg::*;

  localparam int LONG_HOLD     = 400;
  localparam int ALIGN_PER_GAP = 6;
  localparam int TARGET_ITEMS  = 1600;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 600;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_wr_en     = 1'b0;
  logic [SYM_W-1:0]     cfg_wr_data   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  idle_mode_e       idle_mode     = IDLE_NONE;
  int               items_sent    = 0;
  int               hold_requests = 0;
  int               holds_done    = 0;
  logic [SYM_W-1:0] cur_gap       = GAP_RESET;
  int unsigned      error_count;
  int unsigned      pending;

  always #5 clk = ~clk;

  indel_left_align_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  indel_align_checker column_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls per mode, plus long hold-offs on request
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        m_axis_tready <= 1'b0;
        for (int k = 1; k < LONG_HOLD; k++) @(negedge clk);
        holds_done++;
      end else begin
        case (idle_mode)
          IDLE_RECV: m_axis_tready <= ($urandom_range(99) >= 86);
          IDLE_BOTH: m_axis_tready <= ($urandom_range(99) >= 8);
          default:   m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_item(logic op, logic [SYM_W-1:0] rs, logic [SYM_W-1:0] fs,
                           logic last, logic [IDX_W-1:0] idx);
    @(negedge clk);
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 86) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 8)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, idx, fs, rs};
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // index field is don't-care on loads, so it carries noise
  task automatic load_column(logic [SYM_W-1:0] rs, logic [SYM_W-1:0] fs, logic last);
    send_item(OP_LOAD, rs, fs, last, IDX_W'($urandom_range(511)));
  endtask

  task automatic read_column(int idx);
    send_item(OP_READ, SYM_W'($urandom), SYM_W'($urandom), 1'($urandom_range(1)),
              IDX_W'(idx));
  endtask

  task automatic park_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_gap(logic [SYM_W-1:0] value);
    park_input();
    repeat (16) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_gap = value;
  endtask

  // Columns favor repeated bases so indels usually sit next to a homopolymer
  // and have somewhere to slide.
  task automatic send_alignment(int n);
    logic [SYM_W-1:0] bases [4] = '{8'd65, 8'd67, 8'd71, 8'd84};
    logic [SYM_W-1:0] prev_base;
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] rs;
    logic [SYM_W-1:0] fs;
    int               held;
    int               roll;
    int               idx;
    held      = (n > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : n;
    prev_base = bases[0];
    for (int c = 0; c < n; c++) begin
      base = $urandom_range(1) ? prev_base : bases[$urandom_range(3)];
      roll = $urandom_range(99);
      if (roll < 60) begin
        rs = base;
        fs = base;
      end else if (roll < 75) begin
        rs = cur_gap;
        fs = base;
      end else if (roll < 90) begin
        rs = base;
        fs = cur_gap;
      end else if (roll < 93) begin
        rs = cur_gap;
        fs = cur_gap;
      end else begin
        rs = SYM_W'($urandom_range(255));
        fs = SYM_W'($urandom_range(255));
      end
      prev_base = base;
      load_column(rs, fs, c == n - 1);
      // peek at loaded columns now and then, mostly before justification
      if ($urandom_range(99) < 4) read_column($urandom_range((c < 511) ? c : 511));
    end
    repeat ($urandom_range(1, 5)) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        idx = $urandom_range(held - 1);
      end else if (roll < 90) begin
        idx = held + $urandom_range(4);
        if (idx > 511) idx = 511;
      end else begin
        idx = $urandom_range(511);
      end
      read_column(idx);
    end
  endtask

  initial begin : stimulus
    logic [SYM_W-1:0] preset_gaps [3];
    int               directed_idx [12];
    int               align_no;
    int               gap_phase;
    preset_gaps  = '{8'd0, 8'd255, GAP_RESET};
    directed_idx = '{0, 1, 2, 3, 4, 6, 7, 9, 10, 11, 12, 511};
    wait (rst_n === 1'b1);

    // deletion and insertion beside repeats, symbol extremes, a column that
    // is gap on both sides, a trailing insertion, a peek before last
    load_column("A", "A", 1'b0);
    load_column("T", "T", 1'b0);
    load_column("T", "T", 1'b0);
    load_column(GAP_RESET, "T", 1'b0);
    read_column(3);
    load_column("C", "C", 1'b0);
    load_column("G", "G", 1'b0);
    load_column("G", GAP_RESET, 1'b0);
    load_column(8'd0, 8'd255, 1'b0);
    load_column(8'd255, 8'd0, 1'b0);
    load_column(GAP_RESET, GAP_RESET, 1'b0);
    load_column("A", GAP_RESET, 1'b1);
    foreach (directed_idx[i])
      read_column(directed_idx[i]);

    // long output hold-off: reads pile up until the input stalls
    send_alignment(6);
    hold_requests++;
    repeat (10) read_column($urandom_range(7));
    park_input();

    align_no  = 0;
    gap_phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (align_no % ALIGN_PER_GAP == 0) begin
        write_gap((gap_phase < 3) ? preset_gaps[gap_phase] : SYM_W'($urandom_range(255)));
        gap_phase++;
      end
      idle_mode = idle_mode_e'(align_no % 4);
      if (align_no == 13) send_alignment(MAX_COLUMNS_DEF + 8);
      else if ($urandom_range(99) < 90) send_alignment($urandom_range(1, 24));
      else send_alignment($urandom_range(25, 200));
      align_no++;
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
